// ----- rtl/core/boxcar_window_presence_detector_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Boxcar window presence detector: assertion macros
// Shared assertion forms for the checks placed at the end of the top module.
// ----------------------------------------------------------------------------
`ifndef BOXCAR_WINDOW_PRESENCE_DETECTOR_UNIT_DEFINES_SVH
`define BOXCAR_WINDOW_PRESENCE_DETECTOR_UNIT_DEFINES_SVH

// Check that holds whenever the block is out of reset.
`define BWPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is applied.
`define BWPD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bwpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Boxcar window presence detector: package
// Widths, reset values, register indexes and event codes used by the modules.
// ----------------------------------------------------------------------------
package bwpd_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int WINDOW_DEF     = 25;
    localparam int REST_LEVEL_DEF = 1930;

    localparam logic [SAMPLE_W-1:0] UPPER_RESET = 12'd2000;
    localparam logic [SAMPLE_W-1:0] LOWER_RESET = 12'd1700;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [0:0] {
        REG_UPPER = 1'b0,
        REG_LOWER = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_DOCKED   = 2'd1,
        EV_UNDOCKED = 2'd2
    } t_dock_event;

    // Handshake between two pipeline stages.
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// ----- rtl/core/bwpd_cell.sv -----
// ----------------------------------------------------------------------------
// Boxcar window presence detector: window cell
// One slot of the sample window; takes its input (the new sample or its neighbour's) on each shift.
// ----------------------------------------------------------------------------
module bwpd_cell
    import bwpd_pkg::*;
#(
    parameter int REST_LEVEL = REST_LEVEL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_d,
    output logic [SAMPLE_W-1:0] o_q
);

    logic [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= SAMPLE_W'(REST_LEVEL);
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/bwpd_div.sv -----
// ----------------------------------------------------------------------------
// Boxcar window presence detector: window divider
// Divides the running sum by the window length through a registered
// multiplication by a fixed reciprocal.
// ----------------------------------------------------------------------------
module bwpd_div
    import bwpd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SUM_W  = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_stage_ctl          i_ctl,
    input  logic [SUM_W-1:0]    i_sum,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_avg
);

    // The error of the rounded-up reciprocal stays below one step as long as
    // the shift covers the sum width plus the bits of the window length.
    localparam int REC_SH = SUM_W + $clog2(WINDOW);
    localparam int REC_W  = REC_SH + 1;
    localparam logic [REC_W-1:0] REC_M =
        REC_W'(((64'd1 << REC_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int PROD_W = SUM_W + REC_W;

    logic              r_valid;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    assign n_prod = PROD_W'(i_sum) * PROD_W'(REC_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance && i_ctl.valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_avg   = r_prod[REC_SH +: SAMPLE_W];

endmodule

// ----- rtl/core/boxcar_window_presence_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Boxcar window presence detector
// Moving average over a window of hall-sensor samples, compared against an
// upper and a lower bound, with docking and undocking events.
// ----------------------------------------------------------------------------
// Channel   Direction  Word contents
// s_axis    in         sample
// m_axis    out        average, active, dock_event
// cfg       in         upper_bound (index 0), lower_bound (index 1)
//
// One word is taken per cycle unless a stall reaches the input; each result
// passes the window shift and sum, reciprocal multiply and compare stages in turn.
// The sample window is a row of cells that shifts once per accepted word.
// Reset presets every cell to the rest level.
// Each stage holds its word while the next one holds, so bubbles close up
// and a stall on the output reaches the input only when all stages are full.
// ----------------------------------------------------------------------------
module boxcar_window_presence_detector_unit
    import bwpd_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int REST_LEVEL = REST_LEVEL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [11:0] sample
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [11:0] average, [12] active,
                                               // [14:13] dock_event
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [SAMPLE_W-1:0]   i_cfg_wdata
);

`include "boxcar_window_presence_detector_unit_defines.svh"

    localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

    logic [SAMPLE_W-1:0] r_upper;
    logic [SAMPLE_W-1:0] r_lower;

    logic [SAMPLE_W-1:0] w_cell_q [WINDOW];
    logic [SAMPLE_W-1:0] w_sample;
    logic                w_accept;

    logic                r_s1_valid;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;

    logic                w_div_valid;
    logic [SAMPLE_W-1:0] w_avg;
    t_stage_ctl          w_div_ctl;

    logic                w_en_out;
    logic                w_en_div;
    logic                w_en_s1;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic                r_out_active;
    t_dock_event         r_out_ev;
    logic                r_docked;

    logic                n_active;
    t_dock_event         n_ev;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_RESET;
            r_lower <= LOWER_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_UPPER: r_upper <= i_cfg_wdata;
                REG_LOWER: r_lower <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage moves on when it is empty or its successor moves.
    assign w_en_out   = !r_out_valid || i_m_tready;
    assign w_en_div   = !w_div_valid || w_en_out;
    assign w_en_s1    = !r_s1_valid || w_en_div;
    assign o_s_tready = w_en_s1;
    assign w_accept   = i_s_tvalid && w_en_s1;
    assign w_sample   = i_s_tdata[SAMPLE_W-1:0];

    // Window of samples: the newest enters the first cell, the oldest leaves
    // the last one.
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_head
            bwpd_cell #(
                .REST_LEVEL (REST_LEVEL)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_d     (w_sample),
                .o_q     (w_cell_q[g])
            );
        end else begin : g_body
            bwpd_cell #(
                .REST_LEVEL (REST_LEVEL)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_d     (w_cell_q[g-1]),
                .o_q     (w_cell_q[g])
            );
        end
    end

    // Running sum; it also serves as the payload of the first stage.
    assign n_sum = SUM_W'((SUM_W+1)'(r_sum) + (SUM_W+1)'(w_sample)
                          - (SUM_W+1)'(w_cell_q[WINDOW-1]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= SUM_W'(REST_LEVEL * WINDOW);
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_sum <= n_sum;
            end
            if (w_en_s1) begin
                r_s1_valid <= i_s_tvalid;
            end
        end
    end

    assign w_div_ctl.valid   = r_s1_valid;
    assign w_div_ctl.advance = w_en_div;

    bwpd_div #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_sum   (r_sum),
        .o_valid (w_div_valid),
        .o_avg   (w_avg)
    );

    // Bound compare and edge detection on the docked flag.
    always_comb begin
        n_active = (w_avg > r_upper) || (w_avg < r_lower);
        n_ev     = EV_NONE;
        if (!r_docked && n_active) begin
            n_ev = EV_DOCKED;
        end else if (r_docked && !n_active) begin
            n_ev = EV_UNDOCKED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_docked    <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= w_div_valid;
            if (w_div_valid) begin
                r_docked <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && w_div_valid) begin
            r_out_avg    <= w_avg;
            r_out_active <= n_active;
            r_out_ev     <= n_ev;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - SAMPLE_W - 3){1'b0}}, r_out_ev, r_out_active,
                         r_out_avg};

    `BWPD_ASSERT(a_event_matches_active, i_clk, i_rst_n, (r_out_valid && r_out_ev == EV_DOCKED) |-> r_out_active, "docking event without active result")
    `BWPD_ASSERT(a_undock_inactive, i_clk, i_rst_n, (r_out_valid && r_out_ev == EV_UNDOCKED) |-> !r_out_active, "undocking event with active result")
    `BWPD_ASSERT(a_docked_tracks_out, i_clk, i_rst_n, r_out_valid |-> (r_docked == r_out_active), "docked flag differs from held result")
    `BWPD_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, w_accept |=> r_s1_valid, "accepted word did not enter the first stage")
    `BWPD_ASSERT_RST(a_reset_empties_out, i_clk, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule
